// File: rtl/itbe_pkg.sv
// ----------------------------------------------------------------------------
// itbe_pkg: shared types for the I2C target bit engine
// Phase codes, SCL event codes, bus constants and the channel payloads.
// ----------------------------------------------------------------------------
package itbe_pkg;

  localparam int unsigned ADDR_BITS = 7;
  localparam int unsigned BYTE_BITS = 8;

  typedef enum logic [1:0] {
    SCL_LOW  = 2'd0,
    SCL_HIGH = 2'd1,
    SCL_RISE = 2'd2,
    SCL_FALL = 2'd3
  } scl_phase_t;

  typedef enum logic [2:0] {
    PH_STOPPED = 3'd0,
    PH_STARTED = 3'd1,
    PH_WRITING = 3'd2,
    PH_READING = 3'd3,
    PH_ACK     = 3'd4,
    PH_ENDACK  = 3'd5,
    PH_WAITACK = 3'd6,
    PH_IDLE    = 3'd7
  } phase_t;

  typedef struct packed {
    scl_phase_t scl_phase;
    logic       sda_level;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       sda_drive;
    logic       sda_value;
    logic       byte_valid;
    logic [7:0] byte_value;
    phase_t     bus_state;
  } out_item_t;

endpackage

// File: rtl/i2c_target_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_target_bit_engine: I2C target, 7-bit address, bit-level pin events
// Takes one SCL/SDA event per transfer and returns one pin/status result.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | direction | carries
//  --------+------------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, in_data        | into      | one pin event
//  out     | out_valid, out_stall, out_data     | out of    | drive, byte, state
//  cfg     | cfg_valid, cfg_ready, cfg_data     | into      | device address
//
// Each event is decoded combinationally: the bus state registers and the
// event feed short logic whose result lands in the output register, so one
// transfer is taken every clock while the output is not held back.
// A stalled result stays in the output register; a new event is refused only
// while that register is full and stalled.
// Synchronous active-low reset clears the bus state, the address register and
// the output valid flag.
// The address register is always ready; write it only while the bus is quiet.

module i2c_target_bit_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itbe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itbe_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  // Bus state
  itbe_pkg::phase_t phase_r, phase_nxt;
  itbe_pkg::phase_t resume_r, resume_nxt;
  logic [4:0]       bit_ptr_r, bit_ptr_nxt;
  logic [7:0]       rx_shift_r, rx_shift_nxt;
  logic [7:0]       tx_hold_r, tx_hold_nxt;
  logic             prev_sda_r, prev_sda_nxt;
  logic             drive_en_r, drive_en_nxt;
  logic             drive_lvl_r, drive_lvl_nxt;
  logic [6:0]       dev_addr_r;

  // Output register
  logic                out_valid_r;
  itbe_pkg::out_item_t out_data_r, out_data_nxt;

  // Per-event working values
  logic             accept;
  logic             sda;
  logic [7:0]       shift_rx;
  logic [4:0]       shift_ptr;
  logic             byte_done;
  logic [7:0]       byte_val;
  itbe_pkg::phase_t fall_phase;

  // Hold the input while a finished result is still waiting downstream.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sda = in_data.sda_level;

  // Shift one SDA bit into the receive register; the first bit of a byte
  // lands without a shift.
  assign shift_rx  = ((bit_ptr_r != 5'd0) ? {rx_shift_r[6:0], 1'b0} : rx_shift_r)
                     + {7'd0, sda};
  assign shift_ptr = bit_ptr_r + 5'd1;

  // Next bus state for the current event
  always_comb begin
    phase_nxt     = phase_r;
    resume_nxt    = resume_r;
    bit_ptr_nxt   = bit_ptr_r;
    rx_shift_nxt  = rx_shift_r;
    tx_hold_nxt   = tx_hold_r;
    drive_en_nxt  = drive_en_r;
    drive_lvl_nxt = drive_lvl_r;
    prev_sda_nxt  = sda;
    byte_done     = 1'b0;
    byte_val      = 8'd0;
    fall_phase    = phase_r;

    unique case (in_data.scl_phase)
      itbe_pkg::SCL_HIGH: begin
        // Start/stop detection, masked while acknowledging
        if (phase_r != itbe_pkg::PH_ACK) begin
          if (!sda && prev_sda_r) begin
            bit_ptr_nxt  = 5'd0;
            rx_shift_nxt = 8'd0;
            phase_nxt    = itbe_pkg::PH_STARTED;
          end else if (sda && !prev_sda_r) begin
            phase_nxt = itbe_pkg::PH_STOPPED;
          end
        end
      end
      itbe_pkg::SCL_RISE: begin
        if (phase_r == itbe_pkg::PH_STARTED) begin
          rx_shift_nxt = shift_rx;
          bit_ptr_nxt  = shift_ptr;
          // Address and R/W bit complete: compare and pick the direction
          if (shift_ptr > 5'(itbe_pkg::ADDR_BITS)) begin
            rx_shift_nxt = {1'b0, shift_rx[7:1]};
            if (shift_rx[7:1] == dev_addr_r) begin
              phase_nxt = itbe_pkg::PH_ACK;
              if (shift_rx[0]) begin
                resume_nxt  = itbe_pkg::PH_READING;
                bit_ptr_nxt = 5'(itbe_pkg::BYTE_BITS - 1);
                tx_hold_nxt = in_data.tx_byte;
              end else begin
                resume_nxt  = itbe_pkg::PH_WRITING;
                bit_ptr_nxt = 5'd0;
              end
            end else begin
              phase_nxt    = itbe_pkg::PH_STOPPED;
              rx_shift_nxt = 8'd0;
            end
          end
        end else if (phase_r == itbe_pkg::PH_WRITING) begin
          rx_shift_nxt = shift_rx;
          bit_ptr_nxt  = shift_ptr;
          // Data byte complete: report it and acknowledge
          if (shift_ptr == 5'(itbe_pkg::BYTE_BITS)) begin
            byte_done   = 1'b1;
            byte_val    = shift_rx;
            bit_ptr_nxt = 5'd0;
            resume_nxt  = itbe_pkg::PH_WRITING;
            phase_nxt   = itbe_pkg::PH_ACK;
          end
        end else if (phase_r == itbe_pkg::PH_WAITACK) begin
          // Master ACK loads the next byte; NACK ends the read
          if (!sda) begin
            phase_nxt   = resume_r;
            bit_ptr_nxt = 5'(itbe_pkg::BYTE_BITS - 1);
            tx_hold_nxt = in_data.tx_byte;
          end else begin
            phase_nxt = itbe_pkg::PH_IDLE;
          end
        end
      end
      itbe_pkg::SCL_FALL: begin
        if (phase_r == itbe_pkg::PH_ACK) begin
          drive_lvl_nxt = 1'b0;
          drive_en_nxt  = 1'b1;
          fall_phase    = itbe_pkg::PH_ENDACK;
        end else if (phase_r == itbe_pkg::PH_ENDACK) begin
          drive_en_nxt = 1'b0;
          fall_phase   = resume_r;
          rx_shift_nxt = 8'd0;
        end
        phase_nxt = fall_phase;
        // Shift out the next read bit, MSB first; pointer underflow means
        // the byte is done and the master's ACK is due.
        if (fall_phase == itbe_pkg::PH_READING) begin
          if (bit_ptr_r[4]) begin
            drive_en_nxt  = 1'b0;
            drive_lvl_nxt = 1'b0;
            resume_nxt    = itbe_pkg::PH_READING;
            phase_nxt     = itbe_pkg::PH_WAITACK;
          end else begin
            drive_lvl_nxt = tx_hold_r[bit_ptr_r[2:0]] & ~bit_ptr_r[3];
            drive_en_nxt  = 1'b1;
            bit_ptr_nxt   = bit_ptr_r - 5'd1;
          end
        end
      end
      default: begin
        // Low clock level: only the SDA history advances
      end
    endcase
  end

  // Result assembled from the updated state
  always_comb begin
    out_data_nxt.sda_drive  = drive_en_nxt;
    out_data_nxt.sda_value  = drive_lvl_nxt;
    out_data_nxt.byte_valid = byte_done;
    out_data_nxt.byte_value = byte_val;
    out_data_nxt.bus_state  = phase_nxt;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= itbe_pkg::PH_STOPPED;
      resume_r    <= itbe_pkg::PH_STOPPED;
      bit_ptr_r   <= 5'd0;
      rx_shift_r  <= 8'd0;
      tx_hold_r   <= 8'd0;
      prev_sda_r  <= 1'b0;
      drive_en_r  <= 1'b0;
      drive_lvl_r <= 1'b0;
      dev_addr_r  <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        resume_r    <= resume_nxt;
        bit_ptr_r   <= bit_ptr_nxt;
        rx_shift_r  <= rx_shift_nxt;
        tx_hold_r   <= tx_hold_nxt;
        prev_sda_r  <= prev_sda_nxt;
        drive_en_r  <= drive_en_nxt;
        drive_lvl_r <= drive_lvl_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        dev_addr_r <= cfg_data;
      end
      // Fill on a transfer in, drain when the consumer takes the result
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/itbe_chk.sv
// ----------------------------------------------------------------------------
// itbe_chk: port-level checks for the I2C target bit engine
// Watches the channel ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module itbe_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input itbe_pkg::out_item_t out_data
);

  // Held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every transfer in produces a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted event gave no result");

  // Input is only held back by a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A received byte is always followed by the acknowledge phase
  a_byte_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_valid |-> out_data.bus_state == itbe_pkg::PH_ACK)
    else $error("byte reported outside acknowledge");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind i2c_target_bit_engine itbe_chk u_itbe_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
